@@ src/array_statistics_unit_defines.svh @@
// Assertion macros shared by the checker of the array statistics unit.
// No dependencies; included by the checker file.
`ifndef ARRAY_STATISTICS_UNIT_DEFINES_SVH
`define ARRAY_STATISTICS_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("array_statistics_unit check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("array_statistics_unit check failed");

`endif

@@ src/asu_pkg.sv @@
// Package of the array statistics unit: field widths, command codes and
// the command and status structs between controller and datapath. No dependencies.
package asu_pkg;

   localparam int MAX_ELEMENTS_DEFAULT = 1024;
   localparam int VALUE_W = 32;
   localparam int TOTAL_W = 11;
   localparam int FIX_W   = 40;
   localparam int FRAC_W  = 8;

   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   typedef struct packed {
      logic add;
      logic start;
      logic outer_capture;
      logic inner_step;
      logic update;
      logic product;
      logic diff;
      logic mean_start;
      logic dev_start;
      logic div_step;
      logic mean_capture;
      logic load_rsp;
   } asu_cmd_type;

   typedef struct packed {
      logic empty;
      logic inner_done;
      logic outer_last;
      logic div_done;
      logic rsp_free;
   } asu_status_type;

endpackage

@@ src/asu_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module asu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/asu_datapath.sv @@
// Datapath of the array statistics unit: element store, running sum, mode scan,
// products, shared restoring divider and result registers. Uses asu_pkg and asu_ram.
module asu_datapath
   import asu_pkg::*;
#(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  asu_cmd_type                cmd,
   output asu_status_type             status,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_empty_res,
   output logic [TOTAL_W-1:0]         rsp_element_total,
   output logic signed [VALUE_W-1:0]  rsp_minimum,
   output logic signed [VALUE_W-1:0]  rsp_maximum,
   output logic signed [VALUE_W-1:0]  rsp_mode_value,
   output logic [TOTAL_W-1:0]         rsp_mode_count,
   output logic signed [FIX_W-1:0]    rsp_mean_fixed,
   output logic [FIX_W-1:0]           rsp_deviation_fixed,
   output logic                       rsp_dropped
);

   localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
   localparam int ADDR_W = $clog2(MAX_ELEMENTS);
   localparam int SUM_W  = VALUE_W + CNT_W;
   localparam int PROD_W = VALUE_W + CNT_W + 1;
   localparam int DIFF_W = PROD_W + 1;
   localparam int NUM_W  = DIFF_W + FRAC_W + 2;
   localparam int STEP_W = $clog2(NUM_W + 1);
   localparam int REM_W  = CNT_W + 2;

   logic [CNT_W-1:0]         fill_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic                     ovf_ff;
   logic signed [VALUE_W-1:0] min_ff, max_ff;
   logic [CNT_W-1:0]         i_ff, j_ff, cnt_ff, best_cnt_ff;
   logic signed [VALUE_W-1:0] outer_ff, best_val_ff;
   logic                     pend_ff;
   logic signed [PROD_W-1:0] prod_lo_ff, prod_hi_ff;
   logic [DIFF_W-1:0]        dmax_ff;
   logic [NUM_W-1:0]         div_num_ff;
   logic [REM_W-1:0]         div_rem_ff;
   logic [CNT_W:0]           div_den_ff;
   logic [STEP_W-1:0]        div_step_ff;
   logic signed [FIX_W-1:0]  mean_ff;
   logic                     rsp_valid_ff;

   logic                     full;
   logic [ADDR_W-1:0]        rd_addr;
   logic [VALUE_W-1:0]       rd_data;
   logic signed [VALUE_W-1:0] rd_value;
   logic signed [CNT_W:0]    n_signed;
   logic signed [DIFF_W-1:0] dl, dh;
   logic [DIFF_W-1:0]        sum_mag, div_src;
   logic [REM_W-1:0]         rem_sh;
   logic                     q_bit;

   assign full     = (fill_ff == CNT_W'(MAX_ELEMENTS));
   assign rd_addr  = cmd.inner_step ? j_ff[ADDR_W-1:0] : i_ff[ADDR_W-1:0];
   assign rd_value = $signed(rd_data);
   assign n_signed = $signed({1'b0, fill_ff});
   assign dl       = DIFF_W'(sum_ff) - DIFF_W'(prod_lo_ff);
   assign dh       = DIFF_W'(prod_hi_ff) - DIFF_W'(sum_ff);
   assign sum_mag  = sum_ff[SUM_W-1] ? DIFF_W'(-DIFF_W'(sum_ff)) : DIFF_W'(sum_ff);
   assign div_src  = cmd.dev_start ? dmax_ff : sum_mag;
   assign rem_sh   = {div_rem_ff[REM_W-2:0], div_num_ff[NUM_W-1]};
   assign q_bit    = (rem_sh >= REM_W'(div_den_ff));

   asu_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(MAX_ELEMENTS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (cmd.add && !full),
      .wr_addr(fill_ff[ADDR_W-1:0]),
      .wr_data(req_value),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.add) begin
            if (full) begin
               ovf_ff <= 1'b1;
            end else begin
               fill_ff <= fill_ff + CNT_W'(1);
               sum_ff  <= sum_ff + SUM_W'(req_value);
            end
         end
         if (cmd.load_rsp) begin
            fill_ff      <= '0;
            sum_ff       <= '0;
            ovf_ff       <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add && !full) begin
         if (fill_ff == '0 || req_value < min_ff) begin
            min_ff <= req_value;
         end
         if (fill_ff == '0 || req_value > max_ff) begin
            max_ff <= req_value;
         end
      end
      if (cmd.start) begin
         i_ff        <= '0;
         best_cnt_ff <= '0;
         best_val_ff <= '0;
      end
      if (cmd.outer_capture) begin
         outer_ff <= rd_value;
         cnt_ff   <= '0;
         j_ff     <= '0;
         pend_ff  <= 1'b0;
      end
      if (cmd.inner_step) begin
         pend_ff <= (j_ff < fill_ff);
         if (j_ff < fill_ff) begin
            j_ff <= j_ff + CNT_W'(1);
         end
         if (pend_ff && rd_value == outer_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
      if (cmd.update) begin
         if (cnt_ff > best_cnt_ff || (cnt_ff == best_cnt_ff && outer_ff < best_val_ff)) begin
            best_cnt_ff <= cnt_ff;
            best_val_ff <= outer_ff;
         end
         i_ff <= i_ff + CNT_W'(1);
      end
      if (cmd.product) begin
         prod_lo_ff <= min_ff * n_signed;
         prod_hi_ff <= max_ff * n_signed;
      end
      if (cmd.diff) begin
         dmax_ff <= (dl > dh) ? DIFF_W'(dl) : DIFF_W'(dh);
      end
      if (cmd.mean_start || cmd.dev_start) begin
         div_num_ff  <= (NUM_W'(div_src) << (FRAC_W + 1)) + NUM_W'(fill_ff);
         div_rem_ff  <= '0;
         div_den_ff  <= {fill_ff, 1'b0};
         div_step_ff <= '0;
      end
      if (cmd.div_step) begin
         div_rem_ff  <= q_bit ? (rem_sh - REM_W'(div_den_ff)) : rem_sh;
         div_num_ff  <= {div_num_ff[NUM_W-2:0], q_bit};
         div_step_ff <= div_step_ff + STEP_W'(1);
      end
      if (cmd.mean_capture) begin
         mean_ff <= sum_ff[SUM_W-1] ? $signed(FIX_W'(NUM_W'(0) - div_num_ff))
                                    : $signed(FIX_W'(div_num_ff));
      end
      if (cmd.load_rsp) begin
         if (fill_ff == '0) begin
            rsp_empty_res       <= 1'b1;
            rsp_element_total   <= '0;
            rsp_minimum         <= '0;
            rsp_maximum         <= '0;
            rsp_mode_value      <= '0;
            rsp_mode_count      <= '0;
            rsp_mean_fixed      <= '0;
            rsp_deviation_fixed <= '0;
            rsp_dropped         <= 1'b0;
         end else begin
            rsp_empty_res       <= 1'b0;
            rsp_element_total   <= TOTAL_W'(fill_ff);
            rsp_minimum         <= min_ff;
            rsp_maximum         <= max_ff;
            rsp_mode_value      <= best_val_ff;
            rsp_mode_count      <= TOTAL_W'(best_cnt_ff);
            rsp_mean_fixed      <= mean_ff;
            rsp_deviation_fixed <= FIX_W'(div_num_ff);
            rsp_dropped         <= ovf_ff;
         end
      end
   end

   assign status.empty      = (fill_ff == '0);
   assign status.inner_done = (j_ff == fill_ff) && !pend_ff;
   assign status.outer_last = ((i_ff + CNT_W'(1)) == fill_ff);
   assign status.div_done   = (div_step_ff == STEP_W'(NUM_W));
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid         = rsp_valid_ff;

endmodule

@@ src/asu_controller.sv @@
// Controller state machine of the array statistics unit: sequences the mode scan,
// products and divisions. Uses asu_pkg.
module asu_controller
   import asu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_command,
   output logic           req_stall,
   input  asu_status_type status,
   output asu_cmd_type    cmd
);

   typedef enum logic [11:0] {
      S_IDLE          = 12'b000000000001,
      S_OUTER_ISSUE   = 12'b000000000010,
      S_OUTER_CAPTURE = 12'b000000000100,
      S_INNER         = 12'b000000001000,
      S_UPDATE        = 12'b000000010000,
      S_PRODUCT       = 12'b000000100000,
      S_DIFF          = 12'b000001000000,
      S_MEAN_START    = 12'b000010000000,
      S_MEAN_RUN      = 12'b000100000000,
      S_DEV_START     = 12'b001000000000,
      S_DEV_RUN       = 12'b010000000000,
      S_OUTPUT        = 12'b100000000000
   } asu_state_type;

   asu_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_command == CMD_ADD) begin
                  cmd.add = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = status.empty ? S_OUTPUT : S_OUTER_ISSUE;
               end
            end
         end
         S_OUTER_ISSUE: begin
            state_in = S_OUTER_CAPTURE;
         end
         S_OUTER_CAPTURE: begin
            cmd.outer_capture = 1'b1;
            state_in          = S_INNER;
         end
         S_INNER: begin
            cmd.inner_step = 1'b1;
            if (status.inner_done) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.outer_last ? S_PRODUCT : S_OUTER_ISSUE;
         end
         S_PRODUCT: begin
            cmd.product = 1'b1;
            state_in    = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_MEAN_START;
         end
         S_MEAN_START: begin
            cmd.mean_start = 1'b1;
            state_in       = S_MEAN_RUN;
         end
         S_MEAN_RUN: begin
            if (status.div_done) begin
               cmd.mean_capture = 1'b1;
               state_in         = S_DEV_START;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_DEV_START: begin
            cmd.dev_start = 1'b1;
            state_in      = S_DEV_RUN;
         end
         S_DEV_RUN: begin
            if (status.div_done) begin
               state_in = S_OUTPUT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_OUTPUT: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ src/array_statistics_unit.sv @@
// Top level of the array statistics unit: controller and datapath.
// Uses asu_pkg, asu_controller and asu_datapath.
//
// Usage: a req transaction with command add stores req_value; it is taken back to
// back while the controller is idle and gives no response. Adds beyond MAX_ELEMENTS
// are dropped and flagged in the next report. A req transaction with command report
// gives one rsp transaction with count, minimum, maximum, mode, mean and deviation
// (8 fraction bits), then clears the store. req_stall stays high from a report until
// its response is loaded into the output register. The mode scan compares every
// element against every element through the single read port of the store, and the
// mean and deviation each take W steps of a one-bit-per-cycle divider, where W is
// the divider width (55 for 1024 elements). An empty report skips the scan and the
// divisions. Adds are accepted while a response waits; a stalled response holds,
// and the response of a new report waits for the output register to free. Reset
// clears the count, sum and flags; the store itself needs no clearing.
module array_statistics_unit
   import asu_pkg::*;
#(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_command,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_empty_res,
   output logic [TOTAL_W-1:0]        rsp_element_total,
   output logic signed [VALUE_W-1:0] rsp_minimum,
   output logic signed [VALUE_W-1:0] rsp_maximum,
   output logic signed [VALUE_W-1:0] rsp_mode_value,
   output logic [TOTAL_W-1:0]        rsp_mode_count,
   output logic signed [FIX_W-1:0]   rsp_mean_fixed,
   output logic [FIX_W-1:0]          rsp_deviation_fixed,
   output logic                      rsp_dropped
);

   asu_cmd_type    cmd;
   asu_status_type status;

   asu_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_command(req_command),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   asu_datapath #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_empty_res      (rsp_empty_res),
      .rsp_element_total  (rsp_element_total),
      .rsp_minimum        (rsp_minimum),
      .rsp_maximum        (rsp_maximum),
      .rsp_mode_value     (rsp_mode_value),
      .rsp_mode_count     (rsp_mode_count),
      .rsp_mean_fixed     (rsp_mean_fixed),
      .rsp_deviation_fixed(rsp_deviation_fixed),
      .rsp_dropped        (rsp_dropped)
   );

endmodule

@@ src/asu_checker.sv @@
// Port-level checker of the array statistics unit, bound to the top level.
// Uses asu_pkg and the macros of array_statistics_unit_defines.svh.
`include "array_statistics_unit_defines.svh"

module asu_checker
   import asu_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      req_command,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic                      rsp_empty_res,
   input logic [TOTAL_W-1:0]        rsp_element_total,
   input logic signed [VALUE_W-1:0] rsp_minimum,
   input logic signed [VALUE_W-1:0] rsp_maximum,
   input logic signed [VALUE_W-1:0] rsp_mode_value,
   input logic [TOTAL_W-1:0]        rsp_mode_count,
   input logic signed [FIX_W-1:0]   rsp_mean_fixed,
   input logic [FIX_W-1:0]          rsp_deviation_fixed,
   input logic                      rsp_dropped
);

   logic report_taken;
   logic empty_fields_zero;
   logic full_fields_sane;

   assign report_taken      = req_valid && !req_stall && (req_command == CMD_REPORT);
   assign empty_fields_zero = (rsp_element_total == '0) && (rsp_minimum == '0) &&
                              (rsp_maximum == '0) && (rsp_mode_value == '0) &&
                              (rsp_mode_count == '0) && (rsp_mean_fixed == '0) &&
                              (rsp_deviation_fixed == '0) && !rsp_dropped;
   assign full_fields_sane  = (rsp_element_total != '0) && (rsp_minimum <= rsp_maximum) &&
                              (rsp_mode_count != '0) &&
                              (rsp_mode_count <= rsp_element_total);

   `ASU_ASSERT_NEXT(a_report_stalls, clock, reset, report_taken, req_stall)
   `ASU_ASSERT_SAME(a_empty_zero, clock, reset, rsp_valid && rsp_empty_res, empty_fields_zero)
   `ASU_ASSERT_SAME(a_full_sane, clock, reset, rsp_valid && !rsp_empty_res, full_fields_sane)
   `ASU_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid)

endmodule

bind array_statistics_unit asu_checker u_checker (.*);

@@ tb/tb_array_statistics_unit.sv @@
// Self-checking testbench of array_statistics_unit: directed table, then random element sets
// with random gaps and response stalls. Uses asu_pkg and the RTL only; results are predicted here.
module tb_array_statistics_unit;
   import asu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = 1024;

   typedef struct packed {
      logic                      empty_res;
      logic [TOTAL_W-1:0]        element_total;
      logic signed [VALUE_W-1:0] minimum;
      logic signed [VALUE_W-1:0] maximum;
      logic signed [VALUE_W-1:0] mode_value;
      logic [TOTAL_W-1:0]        mode_count;
      logic [FIX_W-1:0]          mean_fixed;
      logic [FIX_W-1:0]          deviation_fixed;
      logic                      dropped;
   } stats_type;

   typedef struct {
      logic                      command;
      logic signed [VALUE_W-1:0] value;
      bit                        typed;
      stats_type                 expected;
   } stim_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_command;
   logic signed [VALUE_W-1:0] req_value;
   logic                      rsp_valid;
   logic                      rsp_stall;
   stats_type                 rsp_seen;

   logic signed [VALUE_W-1:0] held_values[$];
   bit                        adds_dropped;
   stats_type                 pending_stats[$];
   stim_row_type              directed_rows[$];
   int                        mismatch_count;
   int                        reports_checked;
   int                        adds_sent;
   int                        drops_seen;
   bit                        quiet_phase;

   array_statistics_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_empty_res(rsp_seen.empty_res), .rsp_element_total(rsp_seen.element_total),
      .rsp_minimum(rsp_seen.minimum), .rsp_maximum(rsp_seen.maximum),
      .rsp_mode_value(rsp_seen.mode_value), .rsp_mode_count(rsp_seen.mode_count),
      .rsp_mean_fixed(rsp_seen.mean_fixed), .rsp_deviation_fixed(rsp_seen.deviation_fixed),
      .rsp_dropped(rsp_seen.dropped)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_phase || r < 60) begin
         return 0;
      end
      if (r < 94) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(5, 40);
   endfunction

   // Rounds num * 256 / den to nearest, halves away from zero, for num >= 0.
   function automatic longint round_fixed(longint num, longint den);
      return (2 * num * 256 + den) / (2 * den);
   endfunction

   function automatic stats_type compute_statistics();
      stats_type s;
      longint n, total, mag, q, lo, hi, dl, dh;
      int best_count, run;
      s = '0;
      n = longint'(held_values.size());
      if (n == 0) begin
         s.empty_res = 1'b1;
         return s;
      end
      total = 0;
      lo = longint'(held_values[0]);
      hi = longint'(held_values[0]);
      best_count = 0;
      foreach (held_values[i]) begin
         total += longint'(held_values[i]);
         if (longint'(held_values[i]) < lo) lo = longint'(held_values[i]);
         if (longint'(held_values[i]) > hi) hi = longint'(held_values[i]);
         run = 0;
         foreach (held_values[j]) begin
            if (held_values[j] == held_values[i]) run++;
         end
         if (run > best_count || (run == best_count && held_values[i] < s.mode_value)) begin
            best_count = run;
            s.mode_value = held_values[i];
         end
      end
      mag = (total < 0) ? -total : total;
      q = round_fixed(mag, n);
      dl = total - lo * n;
      dh = hi * n - total;
      s.element_total = TOTAL_W'(n);
      s.minimum = VALUE_W'(lo);
      s.maximum = VALUE_W'(hi);
      s.mode_count = TOTAL_W'(best_count);
      s.mean_fixed = FIX_W'((total < 0) ? -q : q);
      s.deviation_fixed = FIX_W'(round_fixed((dl > dh) ? dl : dh, n));
      s.dropped = adds_dropped;
      return s;
   endfunction

   // Updates the predicted store for one accepted transaction; returns the result of a report.
   function automatic stats_type apply_transaction(logic command,
                                                   logic signed [VALUE_W-1:0] value);
      stats_type s;
      s = '0;
      if (command == CMD_ADD) begin
         if (held_values.size() < STORE_DEPTH) begin
            held_values.push_back(value);
         end else begin
            adds_dropped = 1'b1;
         end
      end else begin
         s = compute_statistics();
         held_values.delete();
         adds_dropped = 1'b0;
      end
      return s;
   endfunction

   task automatic send(logic command, logic signed [VALUE_W-1:0] value, bit typed = 0,
                       stats_type typed_result = '0);
      stats_type s;
      int gap;
      req_valid <= 1'b1;
      req_command <= command;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      s = apply_transaction(command, value);
      if (command == CMD_REPORT) begin
         pending_stats.push_back(typed ? typed_result : s);
      end else begin
         adds_sent++;
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_command <= 1'($urandom_range(0, 1));
         req_value <= $urandom;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic void add_row(logic command, logic signed [VALUE_W-1:0] value);
      stim_row_type r;
      r.command = command;
      r.value = value;
      r.typed = 0;
      r.expected = '0;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_typed_report(stats_type expected);
      stim_row_type r;
      r.command = CMD_REPORT;
      r.value = '0;
      r.typed = 1;
      r.expected = expected;
      directed_rows.push_back(r);
   endfunction

   function automatic logic signed [VALUE_W-1:0] random_element(int style);
      case (style)
         0: return $signed($urandom_range(0, 8)) - 4;
         1: return ($urandom_range(0, 1) != 0) ? 32'sh7FFFFFFF : 32'sh80000000;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      rsp_stall = 1'b0;
      forever begin
         rsp_stall <= 1'b0;
         repeat (1 + $urandom_range(0, 12)) @(posedge clock);
         if (!quiet_phase) begin
            rsp_stall <= 1'b1;
            repeat (($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                               : $urandom_range(10, 60)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_stats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected response transaction: %p", rsp_seen);
            end
         end else begin
            if (rsp_seen !== pending_stats[0]) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("response mismatch\n  expected %p\n  actual   %p",
                           pending_stats[0], rsp_seen);
               end
            end
            if (pending_stats[0].dropped) drops_seen++;
            reports_checked++;
            void'(pending_stats.pop_front());
         end
      end
   end

   initial begin
      stats_type t;
      int set_size, style;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_ADD;
      req_value = '0;
      adds_dropped = 1'b0;
      mismatch_count = 0;
      reports_checked = 0;
      adds_sent = 0;
      drops_seen = 0;
      quiet_phase = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      t = '0;
      t.empty_res = 1'b1;
      add_typed_report(t);
      add_row(CMD_ADD, 32'sh80000000);
      t = '0;
      t.element_total = 1;
      t.minimum = 32'sh80000000;
      t.maximum = 32'sh80000000;
      t.mode_value = 32'sh80000000;
      t.mode_count = 1;
      t.mean_fixed = 40'h8000000000;
      add_typed_report(t);
      add_row(CMD_ADD, 32'sh7FFFFFFF);
      t.minimum = 32'sh7FFFFFFF;
      t.maximum = 32'sh7FFFFFFF;
      t.mode_value = 32'sh7FFFFFFF;
      t.mean_fixed = 40'h7FFFFFFF00;
      add_typed_report(t);
      add_row(CMD_ADD, 32'sh80000000);
      add_row(CMD_ADD, 32'sh7FFFFFFF);
      add_row(CMD_REPORT, '0);
      add_row(CMD_ADD, 5);
      add_row(CMD_ADD, -3);
      add_row(CMD_ADD, 5);
      add_row(CMD_ADD, -3);
      add_row(CMD_ADD, 7);
      add_row(CMD_REPORT, '0);
      add_row(CMD_ADD, -1);
      add_row(CMD_ADD, -2);
      add_row(CMD_REPORT, '0);
      add_row(CMD_ADD, 1);
      add_row(CMD_ADD, 0);
      add_row(CMD_ADD, 0);
      add_row(CMD_REPORT, '0);
      t = '0;
      t.empty_res = 1'b1;
      add_typed_report(t);

      @(posedge clock);
      foreach (directed_rows[i]) begin
         send(directed_rows[i].command, directed_rows[i].value,
              directed_rows[i].typed, directed_rows[i].expected);
      end

      for (int k = 0; k < 40; k++) begin
         quiet_phase = ($urandom_range(0, 7) == 0);
         if (k == 20) begin
            // Fill the store past its depth so the report carries the dropped flag.
            for (int i = 0; i < STORE_DEPTH + 6; i++) send(CMD_ADD, random_element(2));
         end else begin
            set_size = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
            style = $urandom_range(0, 2);
            for (int i = 0; i < set_size; i++) begin
               send(CMD_ADD, random_element(($urandom_range(0, 3) == 0) ?
                                            $urandom_range(0, 2) : style));
            end
         end
         send(CMD_REPORT, $urandom);
      end
      quiet_phase = 1'b0;
      req_valid <= 1'b0;

      while (pending_stats.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Covered %0d adds and %0d checked reports, %0d of them with dropped adds.",
               adds_sent, reports_checked, drops_seen);
      $display("Mismatches: %0d.", mismatch_count);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
